### sv/dtmf_pkg.sv
package dtmf_pkg;

  localparam int PHASE_BITS    = 32;
  localparam int SINE_ENTRIES  = 256;
  localparam int SAMPLE_BITS   = 16;
  localparam int ROM_ADDR_BITS = $clog2(SINE_ENTRIES);

  localparam int RATE_BITS   = 40;
  localparam int LENGTH_BITS = 16;
  localparam int COUNT_BITS  = LENGTH_BITS + 1;
  localparam int CFG_IDX_BITS = 2;
  localparam int HZ_BITS     = 11;
  localparam int PROD_BITS   = HZ_BITS + RATE_BITS + 1;
  localparam int STEP_SHIFT  = 48 - PHASE_BITS;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TONE_LEN   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SILENCE    = 2'd2;

  localparam logic [RATE_BITS-1:0]   RESET_PHASE_STEP = 40'd35184372089;
  localparam logic [LENGTH_BITS-1:0] RESET_TONE_LEN   = 16'd3200;
  localparam logic [LENGTH_BITS-1:0] RESET_SILENCE    = 16'd800;

  localparam logic [HZ_BITS-1:0] HZ_ROW0 = 11'd697;
  localparam logic [HZ_BITS-1:0] HZ_ROW1 = 11'd770;
  localparam logic [HZ_BITS-1:0] HZ_ROW2 = 11'd852;
  localparam logic [HZ_BITS-1:0] HZ_ROW3 = 11'd941;
  localparam logic [HZ_BITS-1:0] HZ_COL0 = 11'd1209;
  localparam logic [HZ_BITS-1:0] HZ_COL1 = 11'd1336;
  localparam logic [HZ_BITS-1:0] HZ_COL2 = 11'd1477;
  localparam logic [HZ_BITS-1:0] HZ_COL3 = 11'd1633;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] AMP         = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  localparam int TAYLOR_TERMS = 8;
  localparam logic [63:0] COS_DIV [TAYLOR_TERMS] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240};
  localparam logic [63:0] SIN_DIV [TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic signed [SAMPLE_BITS-1:0] rom_t [SINE_ENTRIES];

  typedef struct packed {
    logic               valid;
    logic [HZ_BITS-1:0] row_hz;
    logic [HZ_BITS-1:0] col_hz;
  } tone_hz_t;

  function automatic rom_t build_rom();
    rom_t               rom;
    logic [63:0]        q;
    logic [63:0]        r;
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic [63:0]        scaled;
    logic signed [63:0] v;
    logic               use_cos;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      q = (64'(k) * 64'd4) >> ROM_ADDR_BITS;
      r = 64'(k) * 64'd4 - q * 64'(SINE_ENTRIES);
      a = (HALF_PI_Q30 * r) / SINE_ENTRIES;
      a2 = (a * a) >> 30;
      use_cos = (q == 64'd0) || (q == 64'd2);
      term = use_cos ? ONE_Q30 : a;
      v = $signed(term);
      for (int i = 0; i < TAYLOR_TERMS; i++) begin
        if (use_cos) begin
          term = ((term * a2) >> 30) / COS_DIV[i];
        end else begin
          term = ((term * a2) >> 30) / SIN_DIV[i];
        end
        if ((i % 2) == 1) begin
          v = v + $signed(term);
        end else begin
          v = v - $signed(term);
        end
      end
      if (v < 0) begin
        v = 64'sd0;
      end
      if (v > $signed(ONE_Q30)) begin
        v = $signed(ONE_Q30);
      end
      mag = $unsigned(v);
      scaled = (mag * AMP + (ONE_Q30 >> 1)) >> 30;
      if ((q == 64'd1) || (q == 64'd2)) begin
        rom[k] = SAMPLE_BITS'(64'd0 - scaled);
      end else begin
        rom[k] = SAMPLE_BITS'(scaled);
      end
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic tone_hz_t decode_key(logic [7:0] c);
    tone_hz_t t;
    t.row_hz = '0;
    t.col_hz = '0;
    case (c)
      "1", "2", "3", "A": t.row_hz = HZ_ROW0;
      "4", "5", "6", "B": t.row_hz = HZ_ROW1;
      "7", "8", "9", "C": t.row_hz = HZ_ROW2;
      "*", "0", "#", "D": t.row_hz = HZ_ROW3;
      default:            t.row_hz = '0;
    endcase
    case (c)
      "1", "4", "7", "*": t.col_hz = HZ_COL0;
      "2", "5", "8", "0": t.col_hz = HZ_COL1;
      "3", "6", "9", "#": t.col_hz = HZ_COL2;
      "A", "B", "C", "D": t.col_hz = HZ_COL3;
      default:            t.col_hz = '0;
    endcase
    t.valid = (t.row_hz != '0) && (t.col_hz != '0);
    return t;
  endfunction

endpackage

### sv/dtmf_digit_tone_sequencer.sv
// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_ready_o   kind_i, digit_code_i, final_digit_i
// out       source     out_valid_o / out_ready_i sample_o, bad_digit_o, run_end_o, idle_o
// cfg       sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// One item per cycle while no held result stalls a tick: an item waits in
// the input register, then the start decode and step multiply or the tick's
// table lookup and phase add run into the state and the result register, the
// last of which drives out_valid_o. Reset leaves the sequencer idle with the
// register defaults loaded. A held result stalls only ticks; starts pass.
module dtmf_digit_tone_sequencer (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic                                        kind_i,
  input  logic [7:0]                                  digit_code_i,
  input  logic                                        final_digit_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic signed [dtmf_pkg::SAMPLE_BITS-1:0]     sample_o,
  output logic                                        bad_digit_o,
  output logic                                        run_end_o,
  output logic                                        idle_o,
  input  logic                                        cfg_we_i,
  input  logic [dtmf_pkg::CFG_IDX_BITS-1:0]           cfg_index_i,
  input  logic [dtmf_pkg::RATE_BITS-1:0]              cfg_data_i
);

  localparam int PB = dtmf_pkg::PHASE_BITS;
  localparam int SB = dtmf_pkg::SAMPLE_BITS;
  localparam int CB = dtmf_pkg::COUNT_BITS;
  localparam int LB = dtmf_pkg::LENGTH_BITS;
  localparam int AB = dtmf_pkg::ROM_ADDR_BITS;
  localparam int XB = dtmf_pkg::PROD_BITS;
  localparam int SH = dtmf_pkg::STEP_SHIFT;

  logic [dtmf_pkg::RATE_BITS-1:0] phase_step_per_hz_q;
  logic [LB-1:0] tone_length_q;
  logic [LB-1:0] silence_length_q;

  logic       s1_valid_q;
  logic       s1_kind_q;
  logic [7:0] s1_digit_q;
  logic       s1_final_q;

  logic [PB-1:0] row_phase_q, row_phase_d;
  logic [PB-1:0] column_phase_q, column_phase_d;
  logic [PB-1:0] row_step_q, row_step_d;
  logic [PB-1:0] column_step_q, column_step_d;
  logic [CB-1:0] sample_count_q, sample_count_d;
  logic          active_q, active_d;
  logic          invalid_q, invalid_d;
  logic          last_q, last_d;

  logic                 out_valid_q;
  logic signed [SB-1:0] sample_q, sample_d;
  logic                 bad_digit_q, bad_digit_d;
  logic                 run_end_q, run_end_d;
  logic                 idle_q, idle_d;

  logic out_free;
  logic s1_go;
  logic s1_start;
  logic s1_tick;

  dtmf_pkg::tone_hz_t key;
  logic [XB-1:0]      row_prod;
  logic [XB-1:0]      col_prod;

  logic            in_tone;
  logic [CB-1:0]   total;
  logic [CB:0]     count_inc;
  logic            end_run;
  logic signed [SB-1:0] row_val;
  logic signed [SB-1:0] col_val;
  logic signed [SB:0]   pair_sum;
  logic signed [SB:0]   pair_half;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_kind_q || out_free);
  assign s1_start   = s1_go && !s1_kind_q;
  assign s1_tick    = s1_go && s1_kind_q;
  assign in_ready_o = !s1_valid_q || s1_go;

  assign key = dtmf_pkg::decode_key(s1_digit_q);
  assign row_prod = XB'(key.row_hz) * XB'(phase_step_per_hz_q) + (XB'(1) << (SH - 1));
  assign col_prod = XB'(key.col_hz) * XB'(phase_step_per_hz_q) + (XB'(1) << (SH - 1));

  assign in_tone   = sample_count_q < CB'(tone_length_q);
  assign total     = CB'(tone_length_q) + (last_q ? CB'(0) : CB'(silence_length_q));
  assign count_inc = (CB + 1)'(sample_count_q) + (CB + 1)'(1);
  assign end_run   = count_inc >= (CB + 1)'(total);

  assign row_val   = dtmf_pkg::SINE_ROM[row_phase_q[PB-1 -: AB]];
  assign col_val   = dtmf_pkg::SINE_ROM[column_phase_q[PB-1 -: AB]];
  assign pair_sum  = (SB + 1)'(row_val) + (SB + 1)'(col_val);
  assign pair_half = (pair_sum + (SB + 1)'(pair_sum[SB])) >>> 1;

  always_comb begin
    row_phase_d    = row_phase_q;
    column_phase_d = column_phase_q;
    row_step_d     = row_step_q;
    column_step_d  = column_step_q;
    sample_count_d = sample_count_q;
    active_d       = active_q;
    invalid_d      = invalid_q;
    last_d         = last_q;
    sample_d       = '0;
    bad_digit_d    = 1'b0;
    run_end_d      = 1'b0;
    idle_d         = 1'b1;
    if (s1_start) begin
      invalid_d      = !key.valid;
      row_step_d     = key.valid ? row_prod[SH +: PB] : '0;
      column_step_d  = key.valid ? col_prod[SH +: PB] : '0;
      row_phase_d    = '0;
      column_phase_d = '0;
      sample_count_d = '0;
      last_d         = s1_final_q;
      active_d       = 1'b1;
    end else if (s1_tick && active_q) begin
      idle_d      = 1'b0;
      bad_digit_d = invalid_q;
      run_end_d   = end_run;
      if (in_tone) begin
        if (!invalid_q) begin
          sample_d = pair_half[SB-1:0];
        end
        row_phase_d    = row_phase_q + row_step_q;
        column_phase_d = column_phase_q + column_step_q;
      end
      sample_count_d = count_inc[CB-1:0];
      if (end_run) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_per_hz_q <= dtmf_pkg::RESET_PHASE_STEP;
      tone_length_q       <= dtmf_pkg::RESET_TONE_LEN;
      silence_length_q    <= dtmf_pkg::RESET_SILENCE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dtmf_pkg::CFG_PHASE_STEP: phase_step_per_hz_q <= cfg_data_i;
        dtmf_pkg::CFG_TONE_LEN:   tone_length_q       <= cfg_data_i[LB-1:0];
        dtmf_pkg::CFG_SILENCE:    silence_length_q    <= cfg_data_i[LB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      row_phase_q    <= '0;
      column_phase_q <= '0;
      row_step_q     <= '0;
      column_step_q  <= '0;
      sample_count_q <= '0;
      active_q       <= 1'b0;
      invalid_q      <= 1'b0;
      last_q         <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_tick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      row_phase_q    <= row_phase_d;
      column_phase_q <= column_phase_d;
      row_step_q     <= row_step_d;
      column_step_q  <= column_step_d;
      sample_count_q <= sample_count_d;
      active_q       <= active_d;
      invalid_q      <= invalid_d;
      last_q         <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_kind_q  <= kind_i;
      s1_digit_q <= digit_code_i;
      s1_final_q <= final_digit_i;
    end
    if (s1_tick) begin
      sample_q    <= sample_d;
      bad_digit_q <= bad_digit_d;
      run_end_q   <= run_end_d;
      idle_q      <= idle_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign bad_digit_o = bad_digit_q;
  assign run_end_o   = run_end_q;
  assign idle_o      = idle_q;

endmodule

### tb/sv/dtmf_digit_tone_sequencer_checker.sv
`timescale 1ns / 100ps
module dtmf_digit_tone_sequencer_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  logic                                    in_ready_i,
  input  logic                                    kind_i,
  input  logic [7:0]                              digit_code_i,
  input  logic                                    final_digit_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_ready_i,
  input  logic signed [dtmf_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                    bad_digit_i,
  input  logic                                    run_end_i,
  input  logic                                    idle_i,
  input  logic                                    cfg_we_i,
  input  logic [dtmf_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [dtmf_pkg::RATE_BITS-1:0]          cfg_data_i,
  output int unsigned                             pending_o,
  output int unsigned                             fail_count_o
);
  import dtmf_pkg::*;

  localparam logic [16*8-1:0] KEYPAD = "123A456B789C*0#D";

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          bad;
    logic                          last;
    logic                          idle;
  } tone_out_t;

  logic signed [SAMPLE_BITS-1:0] wave_tab [SINE_ENTRIES];

  logic [RATE_BITS-1:0]   rate;
  logic [LENGTH_BITS-1:0] tone_len;
  logic [LENGTH_BITS-1:0] gap_len;

  logic [PHASE_BITS-1:0] row_ph;
  logic [PHASE_BITS-1:0] col_ph;
  logic [PHASE_BITS-1:0] row_inc;
  logic [PHASE_BITS-1:0] col_inc;
  logic [COUNT_BITS-1:0] count;
  logic                  running;
  logic                  bad_key;
  logic                  no_gap;

  tone_out_t samples_due [$];
  tone_out_t want;
  tone_out_t got;

  function automatic logic signed [SAMPLE_BITS-1:0] cos_entry(int k);
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    logic [63:0] den;
    logic [63:0] mag;
    logic [63:0] scaled;
    longint      acc;
    quad = (64'(k) * 4) / SINE_ENTRIES;
    rem  = 64'(k) * 4 - quad * SINE_ENTRIES;
    ang  = (HALF_PI_Q30 * rem) / SINE_ENTRIES;
    ang2 = (ang * ang) >> 30;
    if (quad[0] == 1'b0) begin
      term = ONE_Q30;
      den  = 0;
    end else begin
      term = ang;
      den  = 1;
    end
    acc = longint'(term);
    for (int i = 0; i < 8; i++) begin
      term = ((term * ang2) >> 30) / ((den + 1) * (den + 2));
      den  = den + 2;
      if (i % 2 == 1) begin
        acc = acc + longint'(term);
      end else begin
        acc = acc - longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(ONE_Q30)) begin
      acc = longint'(ONE_Q30);
    end
    mag    = 64'(acc);
    scaled = (mag * AMP + (ONE_Q30 >> 1)) >> 30;
    if (quad == 1 || quad == 2) begin
      return SAMPLE_BITS'(64'd0 - scaled);
    end
    return SAMPLE_BITS'(scaled);
  endfunction

  function automatic logic [HZ_BITS-1:0] row_hz(int r);
    case (r)
      0:       return HZ_ROW0;
      1:       return HZ_ROW1;
      2:       return HZ_ROW2;
      default: return HZ_ROW3;
    endcase
  endfunction

  function automatic logic [HZ_BITS-1:0] col_hz(int c);
    case (c)
      0:       return HZ_COL0;
      1:       return HZ_COL1;
      2:       return HZ_COL2;
      default: return HZ_COL3;
    endcase
  endfunction

  function automatic logic [PHASE_BITS-1:0] step_of(logic [HZ_BITS-1:0] hz);
    logic [63:0] p;
    p = 64'(hz) * 64'(rate) + (64'd1 << (STEP_SHIFT - 1));
    return PHASE_BITS'(p >> STEP_SHIFT);
  endfunction

  task automatic load_digit(input logic [7:0] c, input logic f);
    int key;
    key = -1;
    for (int n = 0; n < 16; n++) begin
      if (KEYPAD[8*(15-n) +: 8] == c) begin
        key = n;
      end
    end
    bad_key = (key < 0);
    if (bad_key) begin
      row_inc = '0;
      col_inc = '0;
    end else begin
      row_inc = step_of(row_hz(key / 4));
      col_inc = step_of(col_hz(key % 4));
    end
    row_ph  = '0;
    col_ph  = '0;
    count   = '0;
    no_gap  = f;
    running = 1'b1;
  endtask

  task automatic next_tone_sample(output tone_out_t r);
    longint run_len;
    int     s;
    s = 0;
    r = '0;
    if (!running) begin
      r.idle = 1'b1;
      return;
    end
    run_len = longint'(tone_len) + (no_gap ? 0 : longint'(gap_len));
    if (count < tone_len) begin
      if (!bad_key) begin
        s = (int'(wave_tab[row_ph[PHASE_BITS-1 -: ROM_ADDR_BITS]]) +
             int'(wave_tab[col_ph[PHASE_BITS-1 -: ROM_ADDR_BITS]])) / 2;
      end
      row_ph = row_ph + row_inc;
      col_ph = col_ph + col_inc;
    end
    r.last   = (longint'(count) + 1 >= run_len);
    count    = count + 1'b1;
    r.sample = SAMPLE_BITS'(s);
    r.bad    = bad_key;
    if (r.last) begin
      running = 1'b0;
    end
  endtask

  initial begin
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      wave_tab[k] = cos_entry(k);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate         = RESET_PHASE_STEP;
      tone_len     = RESET_TONE_LEN;
      gap_len      = RESET_SILENCE;
      row_ph       = '0;
      col_ph       = '0;
      row_inc      = '0;
      col_inc      = '0;
      count        = '0;
      running      = 1'b0;
      bad_key      = 1'b0;
      no_gap       = 1'b0;
      samples_due.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PHASE_STEP: rate = cfg_data_i;
          CFG_TONE_LEN:   tone_len = cfg_data_i[LENGTH_BITS-1:0];
          CFG_SILENCE:    gap_len = cfg_data_i[LENGTH_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{sample_i, bad_digit_i, run_end_i, idle_i};
        if (samples_due.size() == 0) begin
          $error("unexpected item: sample %0d", got.sample);
          fail_count_o++;
        end else begin
          want = samples_due.pop_front();
          if (got.sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, got.sample);
            fail_count_o++;
          end
          if (got.bad !== want.bad) begin
            $error("bad_digit: expected %0d, got %0d", want.bad, got.bad);
            fail_count_o++;
          end
          if (got.last !== want.last) begin
            $error("run_end: expected %0d, got %0d", want.last, got.last);
            fail_count_o++;
          end
          if (got.idle !== want.idle) begin
            $error("idle: expected %0d, got %0d", want.idle, got.idle);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (kind_i == KIND_TICK) begin
          next_tone_sample(want);
          samples_due.push_back(want);
        end else begin
          load_digit(digit_code_i, final_digit_i);
        end
      end
      pending_o = samples_due.size();
    end
  end

endmodule

### tb/sv/dtmf_digit_tone_sequencer_test.sv
`timescale 1ns / 100ps
module dtmf_digit_tone_sequencer_test;
  import dtmf_pkg::*;

  localparam logic [16*8-1:0] KEY_CHARS = "0123456789*#ABCD";
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1620;
  localparam int PHASES       = 8;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          kind_i        = 1'b0;
  logic [7:0]                    digit_code_i  = '0;
  logic                          final_digit_i = 1'b0;
  logic                          out_ready_i   = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index_i   = '0;
  logic [RATE_BITS-1:0]          cfg_data_i    = '0;
  logic                          in_ready_o;
  logic                          out_valid_o;
  logic signed [SAMPLE_BITS-1:0] sample_o;
  logic                          bad_digit_o;
  logic                          run_end_o;
  logic                          idle_o;

  int unsigned pending;
  int unsigned fail_count;
  int          src_idle   = 0;
  int          sink_stall = 0;
  int          quiet      = 0;
  int          cur_tone   = RESET_TONE_LEN;
  int          cur_gap    = RESET_SILENCE;
  int          done       = 0;

  dtmf_digit_tone_sequencer dut (.*);

  dtmf_digit_tone_sequencer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .kind_i        (kind_i),
    .digit_code_i  (digit_code_i),
    .final_digit_i (final_digit_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_i      (sample_o),
    .bad_digit_i   (bad_digit_o),
    .run_end_i     (run_end_o),
    .idle_i        (idle_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= (int'($urandom_range(99)) >= sink_stall);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("dtmf_digit_tone_sequencer verification failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic push_item(input bit k, input logic [7:0] c, input bit f);
    while (int'($urandom_range(99)) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    digit_code_i  <= c;
    final_digit_i <= f;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic tick();
    push_item(KIND_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic play(input logic [7:0] c, input bit f, input int n);
    push_item(KIND_START, c, f);
    repeat (n) tick();
  endtask

  // hold the sender until every sample is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic settle();
    drain();
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [RATE_BITS-1:0] rate, input int tone, input int gap);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PHASE_STEP;
    cfg_data_i  <= rate;
    @(posedge clk_i);
    cfg_index_i <= CFG_TONE_LEN;
    cfg_data_i  <= RATE_BITS'(tone);
    @(posedge clk_i);
    cfg_index_i <= CFG_SILENCE;
    cfg_data_i  <= RATE_BITS'(gap);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_tone = tone;
    cur_gap  = gap;
  endtask

  task automatic random_run();
    logic [7:0] c;
    bit         f;
    int         run;
    int         n;
    int         k;
    k = $urandom_range(15);
    c = ($urandom_range(99) < 85) ? KEY_CHARS[8*k +: 8] : 8'($urandom);
    f = 1'($urandom_range(1));
    run = cur_tone + (f ? 0 : cur_gap);
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(run - 1, 0);
    end else begin
      n = run + $urandom_range(2);
    end
    play(c, f, n);
    done += n + 1;
  endtask

  task automatic random_phase(input int p);
    logic [RATE_BITS-1:0] rate;
    int                   target;
    int                   mid;
    bit                   paused;
    settle();
    case (p % 4)
      0: begin src_idle = 0;  sink_stall = 0;  end
      1: begin src_idle = 60; sink_stall = 0;  end
      2: begin src_idle = 0;  sink_stall = 60; end
      default: begin src_idle = 28; sink_stall = 28; end
    endcase
    case ($urandom_range(3))
      0:       rate = RESET_PHASE_STEP;
      1:       rate = RATE_BITS'({$urandom, $urandom});
      2:       rate = '0;
      default: rate = '1;
    endcase
    set_regs(rate, ($urandom_range(4) == 0) ? 1 : $urandom_range(12, 2), $urandom_range(6, 1));
    target = done + RANDOM_ITEMS / PHASES;
    mid    = done + RANDOM_ITEMS / (2 * PHASES);
    paused = 1'b0;
    while (done < target) begin
      random_run();
      if (!paused && done >= mid) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tick();
    play("5", 1'b0, 4);
    settle();
    set_regs(RESET_PHASE_STEP, 3, 2);
    play(8'hFF, 1'b0, 6);
    play("#", 1'b1, 3);
    play("D", 1'b0, 2);
    play("0", 1'b1, 4);
    settle();
    set_regs('0, 0, 1);
    play("7", 1'b1, 1);
    play("9", 1'b0, 2);
    settle();
    set_regs(RATE_BITS'(1), 1, 1);
    play("C", 1'b0, 3);
    settle();
    set_regs('1, 40, 16'hFFFF);
    play("1", 1'b0, 50);
    play("#", 1'b1, 41);

    for (int p = 0; p < PHASES; p++) begin
      random_phase(p);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("dtmf_digit_tone_sequencer verification clean");
    end else begin
      $display("dtmf_digit_tone_sequencer verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/dtmf_pkg.sv
sv/dtmf_digit_tone_sequencer.sv
tb/sv/dtmf_digit_tone_sequencer_checker.sv
tb/sv/dtmf_digit_tone_sequencer_test.sv
